/* hdl/tbeh_pkg.sv */
// Package for the time-binned event histogram: field widths, opcodes,
// configuration register indexes, reset values and the cursor control structs.
// No dependencies.
package tbeh_pkg;

	localparam int MAX_BINS_DEF   = 64;
	localparam int COUNT_BITS_DEF = 24;

	localparam int TIME_W      = 32;
	localparam int BOUND_W     = 40;
	localparam int BIN_COUNT_W = 7;
	localparam int OPCODE_W    = 2;
	localparam int BIN_IDX_W   = 6;
	localparam int COUNT_OUT_W = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd3;

	localparam logic [TIME_W-1:0]      RST_START = 32'd0;
	localparam logic [TIME_W-1:0]      RST_WIDTH = 32'd1;
	localparam logic [BIN_COUNT_W-1:0] RST_COUNT = 7'd50;

	typedef struct packed {
		logic clear;
		logic step;
	} cur_cmd_t;

	typedef struct packed {
		logic advance;
		logic in_range;
	} cur_stat_t;

endpackage

/* hdl/time_binned_event_histogram.sv */
// Top level of the time-binned event histogram: configuration registers, sequencer,
// count update, peaks and the read-out register.
// Depends on tbeh_pkg, tbeh_ram and tbeh_cursor.
//
//  channel  | dir | handshake           | fields
//  ---------+-----+---------------------+------------------------------------------------
//  input    | in  | in_valid / in_stall | opcode, event_time, passes_filter
//  result   | out | out_valid/out_stall | bin_index, local_count, global_count,
//           |     |                     | local_peak, global_peak, last_bin
//  config   | in  | cfg_we              | cfg_index, cfg_data
//
// A clear or an unused opcode completes in the cycle in which it is taken. An add goes
// through acceptance, a cursor step in the shared adder for every bin it passes, the count
// RAM read, then the write; an event past the last bin skips the write. A read-out fetches
// each bin in use in turn through the single RAM read port, an address state then a data
// state per bin, and a stalled result word holds the read-out in place while it is stalled.
// Reset is asynchronous; per-bin valid flags make the store read as zero, so there is
// no clearing pass. The input is stalled while an item is in work.
module time_binned_event_histogram #(
	parameter int MAX_BINS   = tbeh_pkg::MAX_BINS_DEF,
	parameter int COUNT_BITS = tbeh_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tbeh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbeh_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tbeh_pkg::OPCODE_W-1:0]       opcode,
	input  logic [tbeh_pkg::TIME_W-1:0]         event_time,
	input  logic                                passes_filter,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tbeh_pkg::BIN_IDX_W-1:0]      bin_index,
	output logic [tbeh_pkg::COUNT_OUT_W-1:0]    local_count,
	output logic [tbeh_pkg::COUNT_OUT_W-1:0]    global_count,
	output logic [tbeh_pkg::COUNT_OUT_W-1:0]    local_peak,
	output logic [tbeh_pkg::COUNT_OUT_W-1:0]    global_peak,
	output logic                                last_bin
);

	localparam int CW  = $clog2(MAX_BINS + 1);
	localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CB  = COUNT_BITS;
	localparam int NW  = tbeh_pkg::BIN_COUNT_W;
	localparam int IW  = tbeh_pkg::BIN_IDX_W;
	localparam int OW  = tbeh_pkg::COUNT_OUT_W;
	localparam int TW  = tbeh_pkg::TIME_W;
	localparam logic [CB-1:0] CNT_MAX = '1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_STEP = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_RADR = 3'd3;
	localparam logic [2:0] ST_RDAT = 3'd4;

	logic [TW-1:0]       start_q;
	logic [TW-1:0]       width_q;
	logic [NW-1:0]       count_q;
	logic                filter_q;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [TW-1:0]       time_q;
	logic                pass_q;
	logic [AW-1:0]       rd_idx_q;
	logic [MAX_BINS-1:0] vld_q;
	logic                rvld_q;
	logic [CB-1:0]       lpk_q;
	logic [CB-1:0]       gpk_q;

	logic                out_valid_q;
	logic [AW-1:0]       oidx_q;
	logic [CB-1:0]       olcnt_q;
	logic [CB-1:0]       ogcnt_q;
	logic [CB-1:0]       olpk_q;
	logic [CB-1:0]       ogpk_q;
	logic                olast_q;

	logic                in_acc;
	logic                out_load;
	logic [NW-1:0]       n_full;
	logic [CW-1:0]       bins_used;
	logic [CW-1:0]       rd_next;
	logic                rd_last;

	tbeh_pkg::cur_cmd_t  cur_cmd;
	tbeh_pkg::cur_stat_t cur_stat;
	logic [CW-1:0]       cursor;

	logic                ram_we;
	logic                ram_re;
	logic [AW-1:0]       ram_waddr;
	logic [AW-1:0]       ram_raddr;
	logic [2*CB-1:0]     ram_wdata;
	logic [2*CB-1:0]     ram_rdata;

	logic [CB-1:0]       rd_local;
	logic [CB-1:0]       rd_global;
	logic [CB-1:0]       g_new;
	logic [CB-1:0]       l_new;
	logic                l_take;
	logic [CB-1:0]       gp_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= tbeh_pkg::RST_START;
			width_q  <= tbeh_pkg::RST_WIDTH;
			count_q  <= tbeh_pkg::RST_COUNT;
			filter_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbeh_pkg::CFG_START:  start_q  <= cfg_data;
				tbeh_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				tbeh_pkg::CFG_COUNT:  count_q  <= cfg_data[NW-1:0];
				tbeh_pkg::CFG_FILTER: filter_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q == '0) begin
			n_full = NW'(1);
		end else if (count_q > NW'(MAX_BINS)) begin
			n_full = NW'(MAX_BINS);
		end else begin
			n_full = count_q;
		end
	end

	assign bins_used = n_full[CW-1:0];
	assign rd_next   = CW'(rd_idx_q) + CW'(1);
	assign rd_last   = rd_next == bins_used;

	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_RDAT) && (!out_valid_q || !out_stall);

	assign cur_cmd.clear = in_acc && (opcode == tbeh_pkg::OP_CLEAR);
	assign cur_cmd.step  = (state_q == ST_STEP) && cur_stat.advance;

	tbeh_cursor #(
		.MAX_BINS (MAX_BINS)
	) u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cur_cmd),
		.start_time (start_q),
		.bin_width  (width_q),
		.event_time (time_q),
		.bins_used  (bins_used),
		.stat       (cur_stat),
		.cursor     (cursor)
	);

	assign ram_re = ((state_q == ST_STEP) && !cur_stat.advance && cur_stat.in_range) ||
		(state_q == ST_RADR);
	assign ram_raddr = (state_q == ST_RADR) ? rd_idx_q : cursor[AW-1:0];
	assign ram_we    = state_q == ST_UPD;
	assign ram_waddr = cursor[AW-1:0];
	assign ram_wdata = {l_new, g_new};

	tbeh_ram #(
		.WIDTH (2 * CB),
		.DEPTH (MAX_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_local  = rvld_q ? ram_rdata[2*CB-1:CB] : '0;
	assign rd_global = rvld_q ? ram_rdata[CB-1:0] : '0;
	assign l_take    = !filter_q || pass_q;
	assign g_new     = (rd_global == CNT_MAX) ? rd_global : rd_global + CB'(1);
	assign l_new     = (l_take && rd_local != CNT_MAX) ? rd_local + CB'(1) : rd_local;
	assign gp_sel    = (filter_q && gpk_q > lpk_q) ? gpk_q : lpk_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (opcode)
						tbeh_pkg::OP_ADD:  state_d = ST_STEP;
						tbeh_pkg::OP_READ: state_d = ST_RADR;
						default:           state_d = ST_IDLE;
					endcase
				end
			end
			ST_STEP: begin
				if (cur_stat.advance) begin
					state_d = ST_STEP;
				end else if (cur_stat.in_range) begin
					state_d = ST_UPD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_UPD:  state_d = ST_IDLE;
			ST_RADR: state_d = ST_RDAT;
			ST_RDAT: begin
				if (out_load) begin
					state_d = rd_last ? ST_IDLE : ST_RADR;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			lpk_q       <= '0;
			gpk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_re) begin
				rvld_q <= vld_q[ram_raddr];
			end
			if (cur_cmd.clear) begin
				vld_q <= '0;
				lpk_q <= '0;
				gpk_q <= '0;
			end
			if (state_q == ST_UPD) begin
				vld_q[ram_waddr] <= 1'b1;
				if (g_new > gpk_q) begin
					gpk_q <= g_new;
				end
				if (l_new > lpk_q) begin
					lpk_q <= l_new;
				end
			end
			if (in_acc && opcode == tbeh_pkg::OP_READ) begin
				rd_idx_q <= '0;
			end else if (out_load) begin
				rd_idx_q <= rd_next[AW-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			time_q <= event_time;
			pass_q <= passes_filter;
		end
		if (out_load) begin
			oidx_q  <= rd_idx_q;
			olcnt_q <= rd_local;
			ogcnt_q <= rd_global;
			olpk_q  <= lpk_q;
			ogpk_q  <= gp_sel;
			olast_q <= rd_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign bin_index    = IW'(oidx_q);
	assign local_count  = OW'(olcnt_q);
	assign global_count = OW'(ogcnt_q);
	assign local_peak   = OW'(olpk_q);
	assign global_peak  = OW'(ogpk_q);
	assign last_bin     = olast_q;

endmodule

/* hdl/tbeh_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tbeh_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/tbeh_cursor.sv */
// Bin cursor and upper bound, stepped by one shared 40-bit adder and comparator.
// Depends on tbeh_pkg.
module tbeh_cursor #(
	parameter int MAX_BINS = tbeh_pkg::MAX_BINS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tbeh_pkg::cur_cmd_t                   cmd,
	input  logic [tbeh_pkg::TIME_W-1:0]          start_time,
	input  logic [tbeh_pkg::TIME_W-1:0]          bin_width,
	input  logic [tbeh_pkg::TIME_W-1:0]          event_time,
	input  logic [$clog2(MAX_BINS + 1)-1:0]      bins_used,
	output tbeh_pkg::cur_stat_t                  stat,
	output logic [$clog2(MAX_BINS + 1)-1:0]      cursor
);

	localparam int CW = $clog2(MAX_BINS + 1);
	localparam int BW = tbeh_pkg::BOUND_W;
	localparam logic [BW-1:0] BOUND_RST =
		BW'(tbeh_pkg::RST_START) + BW'(tbeh_pkg::RST_WIDTH);

	logic [CW-1:0] cursor_q;
	logic [BW-1:0] bound_q;
	logic [BW-1:0] add_a;
	logic [BW-1:0] add_sum;
	logic          late;

	assign add_a   = cmd.clear ? BW'(start_time) : bound_q;
	assign add_sum = add_a + BW'(bin_width);
	assign late    = BW'(event_time) > bound_q;

	assign stat.in_range = cursor_q < bins_used;
	assign stat.advance  = stat.in_range && late;
	assign cursor        = cursor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			bound_q  <= BOUND_RST;
		end else if (cmd.clear) begin
			cursor_q <= '0;
			bound_q  <= add_sum;
		end else if (cmd.step) begin
			cursor_q <= cursor_q + CW'(1);
			bound_q  <= add_sum;
		end
	end

endmodule

/* hdl/tbeh_checker.sv */
// Port-level checks for the time-binned event histogram and the bind that attaches them.
// Depends on tbeh_pkg and time_binned_event_histogram.
module tbeh_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [tbeh_pkg::OPCODE_W-1:0]    opcode,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [tbeh_pkg::BIN_IDX_W-1:0]   bin_index,
	input logic [tbeh_pkg::COUNT_OUT_W-1:0] local_count,
	input logic [tbeh_pkg::COUNT_OUT_W-1:0] global_count,
	input logic                             last_bin
);

	// A stalled result word stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bin_index) &&
		$stable(local_count) && $stable(global_count) && $stable(last_bin))
		else $error("stalled result word changed");

	// A clear or an unused opcode completes in the cycle it is taken.
	a_quick_ops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall &&
		(opcode == tbeh_pkg::OP_CLEAR || opcode == tbeh_pkg::OP_SPARE)
		|=> !in_stall)
		else $error("input stalled after a single-cycle opcode");

	// An add or a read-out keeps the input stalled in the following cycle.
	a_busy_ops: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall &&
		(opcode == tbeh_pkg::OP_ADD || opcode == tbeh_pkg::OP_READ) |=> in_stall)
		else $error("input not stalled while an item is in work");

	// While a read-out has bins left, the block takes no new item.
	a_readout_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_bin |-> in_stall)
		else $error("new item taken before the read-out ended");

endmodule

bind time_binned_event_histogram tbeh_checker u_tbeh_checker (.*);

/* dv/time_binned_event_histogram_tb.sv */
// Self-checking testbench for time_binned_event_histogram: directed and random
// word streams with a scoreboard class that predicts every read-out bin word.
// Depends on tbeh_pkg and the time_binned_event_histogram RTL.
`timescale 1ns / 100ps

module time_binned_event_histogram_tb;

	localparam logic [tbeh_pkg::COUNT_OUT_W-1:0] CNT_MAX = '1;
	localparam int                               SETTLE  = 100;

	typedef struct packed {
		logic [tbeh_pkg::BIN_IDX_W-1:0]   bin;
		logic [tbeh_pkg::COUNT_OUT_W-1:0] loc_cnt;
		logic [tbeh_pkg::COUNT_OUT_W-1:0] glob_cnt;
		logic [tbeh_pkg::COUNT_OUT_W-1:0] loc_pk;
		logic [tbeh_pkg::COUNT_OUT_W-1:0] glob_pk;
		logic                             is_last;
	} bin_word_t;

	class histogram_scoreboard;
		logic [tbeh_pkg::TIME_W-1:0]      start_tick;
		logic [tbeh_pkg::TIME_W-1:0]      tick_width;
		logic [tbeh_pkg::BIN_COUNT_W-1:0] bins_cfg;
		logic                             filter_on;
		int unsigned                      cursor;
		logic [tbeh_pkg::BOUND_W-1:0]     upper;
		logic [tbeh_pkg::COUNT_OUT_W-1:0] local_tally[tbeh_pkg::MAX_BINS_DEF];
		logic [tbeh_pkg::COUNT_OUT_W-1:0] global_tally[tbeh_pkg::MAX_BINS_DEF];
		logic [tbeh_pkg::COUNT_OUT_W-1:0] local_top;
		logic [tbeh_pkg::COUNT_OUT_W-1:0] global_top;
		bin_word_t                        expected_bins[$];
		int unsigned n_clears, n_adds, n_reads, n_spare, n_checked, n_bad;

		function new();
			start_tick = tbeh_pkg::RST_START;
			tick_width = tbeh_pkg::RST_WIDTH;
			bins_cfg   = tbeh_pkg::RST_COUNT;
			filter_on  = 1'b0;
			n_clears   = 0;
			n_adds     = 0;
			n_reads    = 0;
			n_spare    = 0;
			n_checked  = 0;
			n_bad      = 0;
			wipe_store();
		endfunction

		function void wipe_store();
			cursor = 0;
			upper = tbeh_pkg::BOUND_W'(start_tick) + tbeh_pkg::BOUND_W'(tick_width);
			foreach (local_tally[i]) begin
				local_tally[i]  = '0;
				global_tally[i] = '0;
			end
			local_top  = '0;
			global_top = '0;
		endfunction

		function int unsigned live_bins();
			if (bins_cfg == 0)
				return 1;
			if (bins_cfg > tbeh_pkg::MAX_BINS_DEF)
				return tbeh_pkg::MAX_BINS_DEF;
			return bins_cfg;
		endfunction

		function void set_reg(logic [tbeh_pkg::CFG_IDX_W-1:0] idx,
				logic [tbeh_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				tbeh_pkg::CFG_START:  start_tick = val;
				tbeh_pkg::CFG_WIDTH:  tick_width = val;
				tbeh_pkg::CFG_COUNT:  bins_cfg   = val[tbeh_pkg::BIN_COUNT_W-1:0];
				tbeh_pkg::CFG_FILTER: filter_on  = val[0];
				default: ;
			endcase
		endfunction

		function void bin_event(logic [tbeh_pkg::TIME_W-1:0] t, logic pass);
			int unsigned n;
			n = live_bins();
			while (cursor < n && tbeh_pkg::BOUND_W'(t) > upper) begin
				cursor++;
				upper += tbeh_pkg::BOUND_W'(tick_width);
			end
			if (cursor >= n)
				return;
			if (global_tally[cursor] != CNT_MAX)
				global_tally[cursor]++;
			if (global_tally[cursor] > global_top)
				global_top = global_tally[cursor];
			if (!filter_on || pass) begin
				if (local_tally[cursor] != CNT_MAX)
					local_tally[cursor]++;
				if (local_tally[cursor] > local_top)
					local_top = local_tally[cursor];
			end
		endfunction

		function void note_input_word(logic [tbeh_pkg::OPCODE_W-1:0] op,
				logic [tbeh_pkg::TIME_W-1:0] t, logic pass);
			bin_word_t                        w;
			int unsigned                      n;
			int unsigned                      i;
			logic [tbeh_pkg::COUNT_OUT_W-1:0] gp;
			case (op)
				tbeh_pkg::OP_CLEAR: begin
					n_clears++;
					wipe_store();
				end
				tbeh_pkg::OP_ADD: begin
					n_adds++;
					bin_event(t, pass);
				end
				tbeh_pkg::OP_READ: begin
					n_reads++;
					n = live_bins();
					gp = (filter_on && global_top > local_top) ? global_top : local_top;
					for (i = 0; i < n; i++) begin
						w.bin      = tbeh_pkg::BIN_IDX_W'(i);
						w.loc_cnt  = local_tally[i];
						w.glob_cnt = global_tally[i];
						w.loc_pk   = local_top;
						w.glob_pk  = gp;
						w.is_last  = (i + 1 == n);
						expected_bins.insert(expected_bins.size(), w);
					end
				end
				default: n_spare++;
			endcase
		endfunction

		function void check_bin_word(bin_word_t got);
			bin_word_t want;
			if (expected_bins.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: unexpected word for bin %0d", $realtime, got.bin);
				return;
			end
			want = expected_bins.pop_front();
			n_checked++;
			if (got.bin !== want.bin || got.loc_cnt !== want.loc_cnt
					|| got.glob_cnt !== want.glob_cnt || got.loc_pk !== want.loc_pk
					|| got.glob_pk !== want.glob_pk || got.is_last !== want.is_last) begin
				n_bad++;
				if (n_bad <= 10)
					$display({"%0t: bin word mismatch, expected bin %0d counts %0d/%0d ",
						"peaks %0d/%0d last %0b, got bin %0d counts %0d/%0d ",
						"peaks %0d/%0d last %0b"}, $realtime,
						want.bin, want.loc_cnt, want.glob_cnt, want.loc_pk, want.glob_pk,
						want.is_last, got.bin, got.loc_cnt, got.glob_cnt, got.loc_pk,
						got.glob_pk, got.is_last);
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n        = 1'b0;
	logic                             cfg_we        = 1'b0;
	logic [tbeh_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [tbeh_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                             in_valid      = 1'b0;
	logic                             in_stall;
	logic [tbeh_pkg::OPCODE_W-1:0]    opcode        = '0;
	logic [tbeh_pkg::TIME_W-1:0]      event_time    = '0;
	logic                             passes_filter = 1'b0;
	logic                             out_valid;
	logic                             out_stall     = 1'b0;
	logic [tbeh_pkg::BIN_IDX_W-1:0]   bin_index;
	logic [tbeh_pkg::COUNT_OUT_W-1:0] local_count;
	logic [tbeh_pkg::COUNT_OUT_W-1:0] global_count;
	logic [tbeh_pkg::COUNT_OUT_W-1:0] local_peak;
	logic [tbeh_pkg::COUNT_OUT_W-1:0] global_peak;
	logic                             last_bin;

	int unsigned         in_idle_pct  = 35;
	int unsigned         out_idle_pct = 80;
	histogram_scoreboard board;

	time_binned_event_histogram uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.event_time    (event_time),
		.passes_filter (passes_filter),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bin_index     (bin_index),
		.local_count   (local_count),
		.global_count  (global_count),
		.local_peak    (local_peak),
		.global_peak   (global_peak),
		.last_bin      (last_bin)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_bin_word({bin_index, local_count, global_count, local_peak,
				global_peak, last_bin});
	end

	task automatic send_word(input logic [tbeh_pkg::OPCODE_W-1:0] op,
			input logic [tbeh_pkg::TIME_W-1:0] t, input logic pass);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		event_time    <= t;
		passes_filter <= pass;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.note_input_word(op, t, pass);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [tbeh_pkg::CFG_IDX_W-1:0] idx,
			input logic [tbeh_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic apply_setup(input logic [tbeh_pkg::TIME_W-1:0] start_val,
			input logic [tbeh_pkg::TIME_W-1:0] width_val,
			input logic [tbeh_pkg::BIN_COUNT_W-1:0] count_val, input logic filter_val);
		write_reg(tbeh_pkg::CFG_START, start_val);
		write_reg(tbeh_pkg::CFG_WIDTH, width_val);
		write_reg(tbeh_pkg::CFG_COUNT, tbeh_pkg::CFG_DATA_W'(count_val));
		write_reg(tbeh_pkg::CFG_FILTER, tbeh_pkg::CFG_DATA_W'(filter_val));
		cfg_we <= 1'b0;
	endtask

	// An add can walk the cursor over every bin without producing a word, so
	// wait out that walk once the last expected word has arrived.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_bins.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_segment(input int unsigned quota, input bit open_clear);
		int unsigned                 sent;
		int unsigned                 n_ev;
		int unsigned                 k;
		int unsigned                 r;
		logic [63:0]                 t_now;
		logic [63:0]                 step;
		logic [tbeh_pkg::TIME_W-1:0] t_ev;
		sent = 0;
		while (sent < quota) begin
			if (sent > 0 || open_clear) begin
				send_word(tbeh_pkg::OP_CLEAR, $urandom, 1'($urandom));
				sent++;
			end
			t_now = board.start_tick;
			r = $urandom_range(40);
			if ($urandom_range(3) == 0 && r <= t_now)
				t_now -= r;
			n_ev = $urandom_range(14, 3);
			for (k = 0; k < n_ev; k++) begin
				r = $urandom_range(99);
				if (r < 6) begin
					send_word(tbeh_pkg::OP_SPARE, $urandom, 1'($urandom));
				end else if (r < 10) begin
					send_word(tbeh_pkg::OP_READ, $urandom, 1'($urandom));
					sent++;
				end else if (r < 14) begin
					send_word(tbeh_pkg::OP_ADD, $urandom, 1'($urandom));
					sent++;
				end else if (r < 22) begin
					step = $urandom_range(5, 1);
					t_ev = (t_now >= step) ? tbeh_pkg::TIME_W'(t_now - step) : '0;
					send_word(tbeh_pkg::OP_ADD, t_ev, 1'($urandom));
					sent++;
				end else begin
					if (board.tick_width == 0)
						step = $urandom_range(2);
					else
						step = (64'(board.tick_width) * $urandom_range(200)) / 100;
					t_now += step;
					if (t_now > 64'hFFFF_FFFF)
						t_now = 64'hFFFF_FFFF;
					send_word(tbeh_pkg::OP_ADD, t_now[tbeh_pkg::TIME_W-1:0], 1'($urandom));
					sent++;
				end
			end
			send_word(tbeh_pkg::OP_READ, $urandom, 1'($urandom));
			sent++;
		end
	endtask

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(tbeh_pkg::OP_READ, 32'd0, 1'b0);
		send_word(tbeh_pkg::OP_ADD, 32'd0, 1'b0);
		send_word(tbeh_pkg::OP_ADD, 32'd1, 1'b1);
		send_word(tbeh_pkg::OP_ADD, 32'd0, 1'b1);
		send_word(tbeh_pkg::OP_ADD, 32'd3, 1'b0);
		send_word(tbeh_pkg::OP_ADD, 32'd2, 1'b1);
		send_word(tbeh_pkg::OP_ADD, 32'd49, 1'b1);
		send_word(tbeh_pkg::OP_ADD, 32'd50, 1'b0);
		send_word(tbeh_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1);
		send_word(tbeh_pkg::OP_SPARE, 32'hFFFF_FFFF, 1'b1);
		send_word(tbeh_pkg::OP_READ, 32'hFFFF_FFFF, 1'b1);
		send_word(tbeh_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
		send_word(tbeh_pkg::OP_ADD, 32'd1, 1'b0);
		send_word(tbeh_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
		send_word(tbeh_pkg::OP_READ, 32'd0, 1'b0);
		settle();

		// Zero bin width with a bin count of zero and the filter on: an event
		// before the start lands in the only bin, anything past the bound is lost.
		apply_setup(32'd100, 32'd0, 7'd0, 1'b1);
		send_word(tbeh_pkg::OP_CLEAR, 32'd0, 1'b0);
		send_word(tbeh_pkg::OP_ADD, 32'd50, 1'b0);
		send_word(tbeh_pkg::OP_ADD, 32'd100, 1'b1);
		send_word(tbeh_pkg::OP_ADD, 32'd101, 1'b1);
		send_word(tbeh_pkg::OP_READ, 32'd0, 1'b0);
		settle();

		apply_setup(32'd1000, 32'd10, 7'd8, 1'b1);
		run_segment(28, 1'b1);
		settle();
		apply_setup(32'hFFFF_FF00, 32'hFFFF_FFFF, 7'd64, 1'b0);
		run_segment(28, 1'b1);
		settle();

		in_idle_pct  = 80;
		out_idle_pct = 35;
		apply_setup($urandom, $urandom_range(50, 1), 7'd127, 1'b0);
		run_segment(28, 1'b1);
		settle();
		// No opening clear: the stored counts and the old bound carry over.
		apply_setup($urandom, 32'd5, 7'd3, 1'b1);
		run_segment(28, 1'b0);
		settle();

		in_idle_pct  = 0;
		out_idle_pct = 0;
		apply_setup($urandom, $urandom_range(1000, 1), 7'($urandom_range(64, 1)),
			1'($urandom));
		run_segment(28, 1'b1);
		settle();
		apply_setup(32'hFFFF_FFFF, 32'd1, 7'd1, 1'b1);
		run_segment(28, 1'b1);
		settle();

		$display("Drove %0d clears, %0d adds, %0d read-outs and %0d unused opcodes over",
			board.n_clears, board.n_adds, board.n_reads, board.n_spare);
		$display("eight register settings; %0d bin words compared, %0d in error.",
			board.n_checked, board.n_bad);
		if (board.n_bad == 0 && board.expected_bins.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
